@@ hw/rtl/hccg_pkg.sv @@
package hccg_pkg;

  localparam int PHASE_BITS = 24;
  localparam int ELAPSED_W  = 12;
  localparam int RATE_W     = 16;
  localparam int LEVEL_W    = 8;
  localparam int PROD_W     = 2 * LEVEL_W;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HUE_RATE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ACCENT_LEVEL = CFG_IDX_W'(3);

  localparam logic [RATE_W-1:0]  RST_HUE_RATE     = RATE_W'(839);
  localparam logic [LEVEL_W-1:0] RST_SATURATION   = LEVEL_W'(178);
  localparam logic [LEVEL_W-1:0] RST_BRIGHTNESS   = LEVEL_W'(204);
  localparam logic [LEVEL_W-1:0] RST_ACCENT_LEVEL = LEVEL_W'(76);

  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Exact floor(z / 255) for z up to 255 * 255.
  function automatic logic [LEVEL_W-1:0] div255(input logic [PROD_W-1:0] z);
    logic [PROD_W:0] tmp;
    tmp = {1'b0, z} + {{(LEVEL_W + 1){1'b0}}, z[PROD_W-1:LEVEL_W]} + (PROD_W + 1)'(1);
    return tmp[PROD_W-1:LEVEL_W];
  endfunction

endpackage

@@ hw/rtl/hue_cycling_color_generator_top.sv @@
// A tick is taken only in idle. It runs the 12-step bit-serial phase multiply, then the
// 16-step bit-serial V*S*f product, then waits in the done state until the output register
// is free; only then does the block return to idle, so no new tick is taken until the last
// one has moved into the output register.
// A new tick is taken while the previous result still waits in the output register.
// Reset (rst, synchronous, active high) clears the hue phase to zero, loads the register
// defaults and empties the output register.
module hue_cycling_color_generator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hccg_pkg::ELAPSED_W-1:0]    elapsed_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hccg_pkg::LEVEL_W-1:0]      red,
  output logic [hccg_pkg::LEVEL_W-1:0]      green,
  output logic [hccg_pkg::LEVEL_W-1:0]      blue,
  output logic [hccg_pkg::LEVEL_W-1:0]      accent_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hccg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hccg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hccg_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PHASE = 2'd1;
  localparam logic [1:0] S_HSV   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;

  logic [RATE_W-1:0]     hue_rate;
  logic [LEVEL_W-1:0]    saturation;
  logic [LEVEL_W-1:0]    brightness;
  logic [LEVEL_W-1:0]    accent_level;

  unit_ctl_t             phase_ctl;
  unit_sts_t             phase_sts;
  unit_ctl_t             hsv_ctl;
  unit_sts_t             hsv_sts;
  logic [PHASE_BITS-1:0] hue_phase;
  logic [LEVEL_W-1:0]    hsv_red;
  logic [LEVEL_W-1:0]    hsv_green;
  logic [LEVEL_W-1:0]    hsv_blue;

  logic                  in_take;
  logic                  out_load;

  // Configuration registers accept a beat every cycle and the write takes effect at once, so
  // the user must send writes only while no tick is in flight; the block does not enforce this.
  assign cfg_ready = 1'b1;

  hccg_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (cfg_valid),
    .wr_index     (cfg_index),
    .wr_data      (cfg_data),
    .hue_rate     (hue_rate),
    .saturation   (saturation),
    .brightness   (brightness),
    .accent_level (accent_level)
  );

  // The phase unit owns the hue phase and advances it by elapsed_ms * hue_rate.
  hccg_phase u_phase (
    .clk     (clk),
    .rst     (rst),
    .ctl     (phase_ctl),
    .elapsed (elapsed_ms),
    .rate    (hue_rate),
    .sts     (phase_sts),
    .phase   (hue_phase)
  );

  // The HSV unit starts on the cycle the phase is final and converts it to RGB.
  hccg_hsv u_hsv (
    .clk   (clk),
    .rst   (rst),
    .ctl   (hsv_ctl),
    .phase (hue_phase),
    .sat   (saturation),
    .val   (brightness),
    .sts   (hsv_sts),
    .red   (hsv_red),
    .green (hsv_green),
    .blue  (hsv_blue)
  );

  assign in_ready        = (state == S_IDLE);
  assign in_take         = in_valid & in_ready;
  assign phase_ctl.start = in_take;
  assign hsv_ctl.start   = (state == S_PHASE) & phase_sts.done;

  // The finished color moves into the output register as soon as that slot is free.
  assign out_load = (state == S_DONE) & (~out_valid | out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_take) begin
        state_next = S_PHASE;
      end
      S_PHASE: if (phase_sts.done) begin
        state_next = S_HSV;
      end
      S_HSV:   if (hsv_sts.done) begin
        state_next = S_DONE;
      end
      S_DONE:  if (out_load) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red        <= hsv_red;
      green      <= hsv_green;
      blue       <= hsv_blue;
      accent_out <= accent_level;
    end
  end

  a_phase_done_in_phase: assert property (@(posedge clk) disable iff (rst)
    phase_sts.done |-> (state == S_PHASE))
    else $error("phase unit finished outside the phase step");

  a_hsv_follows_phase: assert property (@(posedge clk) disable iff (rst)
    hsv_ctl.start |=> hsv_sts.busy && !phase_sts.busy)
    else $error("HSV unit did not start after the phase update");

  a_units_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !phase_sts.busy && !hsv_sts.busy)
    else $error("input taken while a unit is still working");

  a_load_only_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten while holding an unread beat");

endmodule

@@ hw/rtl/hccg_cfg.sv @@
module hccg_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [hccg_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [hccg_pkg::CFG_DATA_W-1:0]  wr_data,
  output logic [hccg_pkg::RATE_W-1:0]      hue_rate,
  output logic [hccg_pkg::LEVEL_W-1:0]     saturation,
  output logic [hccg_pkg::LEVEL_W-1:0]     brightness,
  output logic [hccg_pkg::LEVEL_W-1:0]     accent_level
);
  import hccg_pkg::*;

  // Indexes past the register list fall through and change nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      hue_rate     <= RST_HUE_RATE;
      saturation   <= RST_SATURATION;
      brightness   <= RST_BRIGHTNESS;
      accent_level <= RST_ACCENT_LEVEL;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HUE_RATE:     hue_rate     <= wr_data[RATE_W-1:0];
        REG_SATURATION:   saturation   <= wr_data[LEVEL_W-1:0];
        REG_BRIGHTNESS:   brightness   <= wr_data[LEVEL_W-1:0];
        REG_ACCENT_LEVEL: accent_level <= wr_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/hccg_phase.sv @@
module hccg_phase (
  input  logic                               clk,
  input  logic                               rst,
  input  hccg_pkg::unit_ctl_t                ctl,
  input  logic [hccg_pkg::ELAPSED_W-1:0]     elapsed,
  input  logic [hccg_pkg::RATE_W-1:0]        rate,
  output hccg_pkg::unit_sts_t                sts,
  output logic [hccg_pkg::PHASE_BITS-1:0]    phase
);
  import hccg_pkg::*;

  localparam int CNT_W = $clog2(ELAPSED_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ELAPSED_W - 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [ELAPSED_W-1:0]  mult;
  logic [PHASE_BITS-1:0] addend;

  // Shift-and-add, one multiplier bit per cycle, straight into the phase.
  // Bits shifted past the top are whole turns and drop out.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (mult[0]) begin
          phase <= phase + addend;
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mult   <= elapsed;
      addend <= PHASE_BITS'(rate);
    end else if (busy) begin
      mult   <= mult >> 1;
      addend <= addend << 1;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

@@ hw/rtl/hccg_hsv.sv @@
module hccg_hsv (
  input  logic                               clk,
  input  logic                               rst,
  input  hccg_pkg::unit_ctl_t                ctl,
  input  logic [hccg_pkg::PHASE_BITS-1:0]    phase,
  input  logic [hccg_pkg::LEVEL_W-1:0]       sat,
  input  logic [hccg_pkg::LEVEL_W-1:0]       val,
  output hccg_pkg::unit_sts_t                sts,
  output logic [hccg_pkg::LEVEL_W-1:0]       red,
  output logic [hccg_pkg::LEVEL_W-1:0]       green,
  output logic [hccg_pkg::LEVEL_W-1:0]       blue
);
  import hccg_pkg::*;

  localparam int H6_W  = PHASE_BITS + 3;
  localparam int ACC_W = PHASE_BITS + PROD_W;
  localparam int CNT_W = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(PROD_W - 1);

  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;

  logic                  busy;
  logic                  fin;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [2:0]            sector;
  logic [LEVEL_W-1:0]    v;
  logic [PROD_W-1:0]     vs;
  logic [PROD_W-1:0]     vs_sh;
  logic [ACC_W-1:0]      addend;
  logic [ACC_W-1:0]      acc;

  logic [H6_W-1:0]       h6;
  logic [PROD_W-1:0]     hi;
  logic                  frac_nz;
  logic [PROD_W-1:0]     v255;
  logic [PROD_W-1:0]     z_p;
  logic [PROD_W-1:0]     z_q;
  logic [PROD_W-1:0]     z_t;
  logic [LEVEL_W-1:0]    p_lvl;
  logic [LEVEL_W-1:0]    q_lvl;
  logic [LEVEL_W-1:0]    t_lvl;

  assign h6 = {1'b0, phase, 2'b00} + {2'b00, phase, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      fin  <= 1'b0;
      done <= fin;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // acc collects V*S*f one bit of V*S per cycle.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sector <= h6[H6_W-1:PHASE_BITS];
      v      <= val;
      vs     <= PROD_W'(val) * PROD_W'(sat);
      vs_sh  <= PROD_W'(val) * PROD_W'(sat);
      addend <= ACC_W'(h6[PHASE_BITS-1:0]);
      acc    <= '0;
    end else if (busy) begin
      if (vs_sh[0]) begin
        acc <= acc + addend;
      end
      vs_sh  <= vs_sh >> 1;
      addend <= addend << 1;
    end
  end

  // With c = ceil(V*S*f / 2^P): q = floor((255V - c) / 255). For t the
  // same ceiling over (1 - f) collapses to V*S - floor(V*S*f / 2^P).
  always_comb begin
    hi      = acc[ACC_W-1:PHASE_BITS];
    frac_nz = |acc[PHASE_BITS-1:0];
    v255    = {v, {LEVEL_W{1'b0}}} - PROD_W'(v);
    z_p     = v255 - vs;
    z_q     = v255 - (hi + PROD_W'(frac_nz));
    z_t     = v255 - (vs - hi);
    p_lvl   = div255(z_p);
    q_lvl   = div255(z_q);
    t_lvl   = div255(z_t);
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      unique case (sector)
        SEC_0: begin
          red <= v;     green <= t_lvl; blue <= p_lvl;
        end
        SEC_1: begin
          red <= q_lvl; green <= v;     blue <= p_lvl;
        end
        SEC_2: begin
          red <= p_lvl; green <= v;     blue <= t_lvl;
        end
        SEC_3: begin
          red <= p_lvl; green <= q_lvl; blue <= v;
        end
        SEC_4: begin
          red <= t_lvl; green <= p_lvl; blue <= v;
        end
        default: begin
          red <= v;     green <= p_lvl; blue <= q_lvl;
        end
      endcase
    end
  end

  assign sts.busy = busy | fin;
  assign sts.done = done;

endmodule
